// File: rtl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants of the stack machine executor: command and
// status codes, transaction structs and stack sizing.
// ----------------------------------------------------------------------------
package sme_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DATA_W      = 16;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int AW          = $clog2(STACK_DEPTH);

	typedef enum logic [4:0] {
		CMD_RESET   = 5'd0,
		CMD_PRELOAD = 5'd1,
		CMD_START   = 5'd2,
		CMD_PUSH    = 5'd3,
		CMD_JMPIF   = 5'd4,
		CMD_JMPZ    = 5'd5,
		CMD_EQ      = 5'd6,
		CMD_NOT     = 5'd7,
		CMD_AND     = 5'd8,
		CMD_OR      = 5'd9,
		CMD_XOR     = 5'd10,
		CMD_GRT     = 5'd11,
		CMD_ADD     = 5'd12,
		CMD_SUB     = 5'd13,
		CMD_MUL     = 5'd14,
		CMD_DIV     = 5'd15,
		CMD_END     = 5'd16
	} sme_cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_UNDER   = 3'd1,
		ST_OVER    = 3'd2,
		ST_DIVZ    = 3'd3,
		ST_IGNORED = 3'd4
	} sme_status_t;

	typedef struct packed {
		logic [4:0]               command;
		logic signed [DATA_W-1:0] operand;
	} sme_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic [4:0]               stack_count;
		logic [2:0]               status;
		logic                     running;
		logic                     finished;
	} sme_out_t;

endpackage

// File: rtl/sme_div.sv
// ----------------------------------------------------------------------------
// sme_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Restarts whenever start is high; done stays high until the next start.
// ----------------------------------------------------------------------------
module sme_div
	import sme_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] dividend,
	input  logic signed [DATA_W-1:0] divisor,
	output logic signed [DATA_W-1:0] quotient,
	output logic                     done
);

	localparam int CNT_W = $clog2(DATA_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W+1:0] trial;
	logic [DATA_W-1:0] mag_dd;
	logic [DATA_W-1:0] mag_dv;

	assign mag_dd = dividend[DATA_W-1] ? DATA_W'(-dividend) : dividend;
	assign mag_dv = divisor[DATA_W-1] ? DATA_W'(-divisor) : divisor;
	assign trial  = {1'b0, rem_q, quo_q[DATA_W-1]} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DATA_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_dd;
			dvs_q <= mag_dv;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			if (!trial[DATA_W+1]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? DATA_W'(-quo_q) : quo_q;
	assign done     = done_q;

endmodule

// File: rtl/stack_machine_executor.sv
// ----------------------------------------------------------------------------
// stack_machine_executor
// Microcoded stack machine: a dispatch step picks a short routine in a
// control ROM that drives the stack memory, top register, ALU and divider.
// ----------------------------------------------------------------------------
// execution: binary ops and jmpif read the entry below before their routine
// step; div reads it, starts the divider and waits, or writes zero on a zero
// divisor; a stalled result holds the last step until it clears
// throughput: one transaction executes at a time; the next is taken once the
// microprogram returns to its idle step, while the last result may still wait
// reset: clears stack pointer, flags and sequencer; stack memory is not cleared
// ----------------------------------------------------------------------------
module stack_machine_executor
	import sme_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  sme_in_t  cmd,
	output logic     res_valid,
	input  logic     res_stall,
	output sme_out_t res
);

	typedef logic [3:0] upc_t;

	localparam upc_t U_IDLE    = 4'd0;
	localparam upc_t U_FINISH  = 4'd1;
	localparam upc_t U_PUSH    = 4'd2;
	localparam upc_t U_RESET   = 4'd3;
	localparam upc_t U_START   = 4'd4;
	localparam upc_t U_END     = 4'd5;
	localparam upc_t U_CLRSKIP = 4'd6;
	localparam upc_t U_NOT     = 4'd7;
	localparam upc_t U_JMPIF   = 4'd8;
	localparam upc_t U_JPOP    = 4'd9;
	localparam upc_t U_BIN     = 4'd10;
	localparam upc_t U_BALU    = 4'd11;
	localparam upc_t U_DIV     = 4'd12;
	localparam upc_t U_DGO     = 4'd13;
	localparam upc_t U_DWAIT   = 4'd14;
	localparam upc_t U_DZERO   = 4'd15;

	typedef enum logic [3:0] {
		A_NONE, A_PUSH, A_CLEAR, A_START, A_END, A_CLRSKIP, A_NOT,
		A_READ, A_POPTOP, A_ALU, A_DIVGO, A_DIVWB, A_ZEROWB
	} act_t;

	typedef enum logic [2:0] {
		SQ_DISPATCH, SQ_NEXT, SQ_DONE, SQ_JZERO, SQ_WAITDONE
	} seq_t;

	typedef struct packed {
		act_t act;
		seq_t seq;
		upc_t tgt;
	} uword_t;

	function automatic uword_t ucode(upc_t a);
		uword_t w;
		w = '{act: A_NONE, seq: SQ_DONE, tgt: U_IDLE};
		unique case (a)
			U_IDLE:    w = '{act: A_NONE,    seq: SQ_DISPATCH, tgt: U_IDLE};
			U_FINISH:  w = '{act: A_NONE,    seq: SQ_DONE,     tgt: U_IDLE};
			U_PUSH:    w = '{act: A_PUSH,    seq: SQ_DONE,     tgt: U_IDLE};
			U_RESET:   w = '{act: A_CLEAR,   seq: SQ_DONE,     tgt: U_IDLE};
			U_START:   w = '{act: A_START,   seq: SQ_DONE,     tgt: U_IDLE};
			U_END:     w = '{act: A_END,     seq: SQ_DONE,     tgt: U_IDLE};
			U_CLRSKIP: w = '{act: A_CLRSKIP, seq: SQ_DONE,     tgt: U_IDLE};
			U_NOT:     w = '{act: A_NOT,     seq: SQ_DONE,     tgt: U_IDLE};
			U_JMPIF:   w = '{act: A_READ,    seq: SQ_NEXT,     tgt: U_IDLE};
			U_JPOP:    w = '{act: A_POPTOP,  seq: SQ_DONE,     tgt: U_IDLE};
			U_BIN:     w = '{act: A_READ,    seq: SQ_NEXT,     tgt: U_IDLE};
			U_BALU:    w = '{act: A_ALU,     seq: SQ_DONE,     tgt: U_IDLE};
			U_DIV:     w = '{act: A_READ,    seq: SQ_NEXT,     tgt: U_IDLE};
			U_DGO:     w = '{act: A_DIVGO,   seq: SQ_JZERO,    tgt: U_DZERO};
			U_DWAIT:   w = '{act: A_DIVWB,   seq: SQ_WAITDONE, tgt: U_IDLE};
			U_DZERO:   w = '{act: A_ZEROWB,  seq: SQ_DONE,     tgt: U_IDLE};
			default:   w = '{act: A_NONE,    seq: SQ_DONE,     tgt: U_IDLE};
		endcase
		return w;
	endfunction

	upc_t                     upc_q;
	logic [4:0]               cmd_q;
	logic signed [DATA_W-1:0] opnd_q;
	logic [SP_W-1:0]          sp_q;
	logic                     started_q;
	logic                     skip_q;
	logic                     ended_q;
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] rd_q;
	sme_status_t              status_q;
	logic                     res_valid_q;
	sme_out_t                 res_q;

	logic signed [DATA_W-1:0] stack_mem [STACK_DEPTH];

	uword_t                   uw;
	logic                     accept;
	logic                     res_busy;
	logic                     exec;
	logic                     finish;
	upc_t                     upc_d;
	upc_t                     entry;
	sme_status_t              entry_st;
	logic [SP_W-1:0]          sp_d;
	logic [SP_W-1:0]          sp_m1;
	logic [SP_W-1:0]          sp_m2;
	logic                     started_d;
	logic                     skip_d;
	logic                     ended_d;
	logic signed [DATA_W-1:0] top_d;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic signed [DATA_W-1:0] alu;
	logic signed [2*DATA_W-1:0] prod;
	logic signed [DATA_W-1:0] quot;
	logic                     div_done;
	logic                     full;
	logic                     has1;
	logic                     has2;

	assign uw        = ucode(upc_q);
	assign cmd_stall = (upc_q != U_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign res_busy  = res_valid_q && res_stall;
	assign sp_m1     = sp_q - SP_W'(1);
	assign sp_m2     = sp_q - SP_W'(2);
	assign full      = (sp_q >= SP_W'(STACK_DEPTH));
	assign has1      = (sp_q != '0);
	assign has2      = (sp_q >= SP_W'(2));

	// dispatch decode
	always_comb begin
		entry    = U_FINISH;
		entry_st = ST_IGNORED;
		if (cmd.command == CMD_RESET) begin
			entry    = U_RESET;
			entry_st = ST_OK;
		end else if (ended_q || cmd.command > CMD_END) begin
			entry    = U_FINISH;
			entry_st = ST_IGNORED;
		end else if (!started_q) begin
			if (cmd.command == CMD_PRELOAD) begin
				entry    = full ? U_FINISH : U_PUSH;
				entry_st = full ? ST_OVER : ST_OK;
			end else if (cmd.command == CMD_START) begin
				entry    = U_START;
				entry_st = ST_OK;
			end
		end else if (skip_q) begin
			if (cmd.command == CMD_JMPZ) begin
				entry    = U_CLRSKIP;
				entry_st = ST_OK;
			end
		end else begin
			case (cmd.command) inside
				CMD_PRELOAD: begin
					entry    = U_FINISH;
					entry_st = ST_IGNORED;
				end
				CMD_START, CMD_JMPZ: begin
					entry    = U_FINISH;
					entry_st = ST_OK;
				end
				CMD_PUSH: begin
					entry    = full ? U_FINISH : U_PUSH;
					entry_st = full ? ST_OVER : ST_OK;
				end
				CMD_JMPIF: begin
					entry    = has1 ? U_JMPIF : U_FINISH;
					entry_st = has1 ? ST_OK : ST_UNDER;
				end
				CMD_NOT: begin
					entry    = has1 ? U_NOT : U_FINISH;
					entry_st = has1 ? ST_OK : ST_UNDER;
				end
				CMD_END: begin
					entry    = U_END;
					entry_st = ST_OK;
				end
				CMD_DIV: begin
					entry    = has2 ? U_DIV : U_FINISH;
					entry_st = !has2 ? ST_UNDER : ((top_q == '0) ? ST_DIVZ : ST_OK);
				end
				default: begin
					entry    = has2 ? U_BIN : U_FINISH;
					entry_st = has2 ? ST_OK : ST_UNDER;
				end
			endcase
		end
	end

	// alu, a is the top and b the entry below
	assign prod = rd_q * top_q;

	always_comb begin
		alu = '0;
		case (cmd_q)
			CMD_EQ:  alu = DATA_W'(top_q == rd_q);
			CMD_AND: alu = DATA_W'((top_q != '0) && (rd_q != '0));
			CMD_OR:  alu = DATA_W'((top_q != '0) || (rd_q != '0));
			CMD_XOR: alu = DATA_W'((top_q != '0) != (rd_q != '0));
			CMD_GRT: alu = DATA_W'(top_q > rd_q);
			CMD_ADD: alu = rd_q + top_q;
			CMD_SUB: alu = rd_q - top_q;
			CMD_MUL: alu = prod[DATA_W-1:0];
			default: alu = '0;
		endcase
	end

	sme_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (uw.act == A_DIVGO),
		.dividend (rd_q),
		.divisor  (top_q),
		.quotient (quot),
		.done     (div_done)
	);

	// sequencer
	always_comb begin
		upc_d  = upc_q;
		exec   = 1'b0;
		finish = 1'b0;
		case (uw.seq)
			SQ_DISPATCH: begin
				if (accept) upc_d = entry;
			end
			SQ_NEXT: begin
				exec  = 1'b1;
				upc_d = upc_q + upc_t'(1);
			end
			SQ_JZERO: begin
				exec  = 1'b1;
				upc_d = (top_q == '0) ? uw.tgt : upc_q + upc_t'(1);
			end
			SQ_DONE: begin
				exec   = !res_busy;
				finish = !res_busy;
			end
			SQ_WAITDONE: begin
				exec   = div_done && !res_busy;
				finish = div_done && !res_busy;
			end
			default: upc_d = U_IDLE;
		endcase
		if (finish) upc_d = U_IDLE;
	end

	// datapath next state
	always_comb begin
		sp_d      = sp_q;
		started_d = started_q;
		skip_d    = skip_q;
		ended_d   = ended_q;
		top_d     = top_q;
		wr_en     = 1'b0;
		wr_addr   = sp_m2[AW-1:0];
		wr_data   = alu;
		if (exec) begin
			case (uw.act)
				A_PUSH: begin
					wr_en   = 1'b1;
					wr_addr = sp_q[AW-1:0];
					wr_data = opnd_q;
					sp_d    = sp_q + SP_W'(1);
					top_d   = opnd_q;
				end
				A_CLEAR: begin
					sp_d      = '0;
					started_d = 1'b0;
					skip_d    = 1'b0;
					ended_d   = 1'b0;
					top_d     = '0;
				end
				A_START:   started_d = 1'b1;
				A_END:     ended_d = 1'b1;
				A_CLRSKIP: skip_d = 1'b0;
				A_NOT: begin
					wr_en   = 1'b1;
					wr_addr = sp_m1[AW-1:0];
					wr_data = DATA_W'(top_q == '0);
					top_d   = DATA_W'(top_q == '0);
				end
				A_POPTOP: begin
					sp_d   = sp_m1;
					skip_d = (top_q != '0);
					top_d  = (sp_m1 == '0) ? '0 : rd_q;
				end
				A_ALU: begin
					wr_en   = 1'b1;
					wr_data = alu;
					sp_d    = sp_m1;
					top_d   = alu;
				end
				A_DIVWB: begin
					wr_en   = 1'b1;
					wr_data = quot;
					sp_d    = sp_m1;
					top_d   = quot;
				end
				A_ZEROWB: begin
					wr_en   = 1'b1;
					wr_data = '0;
					sp_d    = sp_m1;
					top_d   = '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= U_IDLE;
			sp_q        <= '0;
			started_q   <= 1'b0;
			skip_q      <= 1'b0;
			ended_q     <= 1'b0;
			top_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			upc_q     <= upc_d;
			sp_q      <= sp_d;
			started_q <= started_d;
			skip_q    <= skip_d;
			ended_q   <= ended_d;
			top_q     <= top_d;
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd.command;
			opnd_q   <= cmd.operand;
			status_q <= entry_st;
		end
		if (finish) begin
			res_q.top_value   <= top_d;
			res_q.stack_count <= 5'(sp_d);
			res_q.status      <= status_q;
			res_q.running     <= started_d && !ended_d;
			res_q.finished    <= ended_d;
		end
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (wr_en) stack_mem[wr_addr] <= wr_data;
		if (exec && uw.act == A_READ) rd_q <= stack_mem[sp_m2[AW-1:0]];
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.stack_count != '0 || res.top_value == '0))
		else $error("nonzero top on empty stack");

	a_run_fin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.running && res.finished))
		else $error("running and finished together");

	a_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (upc_q != U_IDLE))
		else $error("accepted transaction not dispatched");

	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_DIVZ) |-> (res.top_value == '0))
		else $error("divide by zero result not zero");

endmodule

// File: bench/tb_stack_machine_executor.sv
// ----------------------------------------------------------------------------
// tb_stack_machine_executor
// Self-checking bench for the stack machine executor. A queue of commands
// (a short directed program, then random programs and noise) feeds a
// valid/stall driver. Every accepted command runs through an in-bench model
// of the operand stack and its flags. Each returned result is compared field
// by field with the oldest predicted one. Sends idle, results stall at random.
// ----------------------------------------------------------------------------
module tb_stack_machine_executor;
	import sme_pkg::*;

	localparam int RANDOM_ITEMS   = 1750;
	localparam int GAP_MAX        = 9;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int CMD_TOP        = (1 << $bits(sme_cmd_t)) - 1;
	localparam logic [DATA_W-1:0] MAX_POS = 16'h7fff;
	localparam logic [DATA_W-1:0] MAX_NEG = 16'h8000;

	typedef struct {
		sme_in_t item;
		bit      hold;
	} pending_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_stall;
	sme_in_t  cmd       = '0;
	logic     res_valid;
	logic     res_stall = 1'b0;
	sme_out_t res;

	stack_machine_executor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// machine state as predicted
	logic signed [DATA_W-1:0] stk [STACK_DEPTH];
	int unsigned sp       = 0;
	bit          started  = 1'b0;
	bit          skipping = 1'b0;
	bit          ended    = 1'b0;

	pending_t pending_q [$];
	pending_t next_req;
	sme_out_t expected_q [$];
	sme_out_t want;
	bit       hold_next    = 1'b0;
	bit       cmd_fired    = 1'b0;
	bit       res_fired    = 1'b0;
	bit       send_burst   = 1'b0;
	bit       recv_burst   = 1'b0;
	int       send_gap     = 0;
	int       stall_left   = 0;
	int       stall_draw;
	int       quiet_cycles = 0;
	int       sent_count   = 0;
	int       result_count = 0;
	int       prog_count   = 0;
	int       error_count  = 0;
	int       status_seen [8];

	function automatic sme_status_t push_word(logic signed [DATA_W-1:0] v);
		if (sp >= STACK_DEPTH)
			return ST_OVER;
		stk[sp] = v;
		sp++;
		return ST_OK;
	endfunction

	function automatic sme_out_t exec_instr(sme_in_t it);
		sme_out_t r;
		sme_status_t st;
		logic signed [DATA_W-1:0] a, b, v;
		st = ST_OK;
		if (it.command == CMD_RESET) begin
			sp = 0;
			started = 1'b0;
			skipping = 1'b0;
			ended = 1'b0;
		end else if (ended || it.command > CMD_END) begin
			st = ST_IGNORED;
		end else if (!started) begin
			if (it.command == CMD_PRELOAD)
				st = push_word(it.operand);
			else if (it.command == CMD_START)
				started = 1'b1;
			else
				st = ST_IGNORED;
		end else if (skipping) begin
			if (it.command == CMD_JMPZ)
				skipping = 1'b0;
			else
				st = ST_IGNORED;
		end else begin
			case (it.command)
				CMD_PRELOAD: st = ST_IGNORED;
				CMD_START, CMD_JMPZ: ;
				CMD_PUSH: st = push_word(it.operand);
				CMD_END: ended = 1'b1;
				CMD_JMPIF: begin
					if (sp < 1) begin
						st = ST_UNDER;
					end else begin
						sp--;
						if (stk[sp] != 0)
							skipping = 1'b1;
					end
				end
				CMD_NOT: begin
					if (sp < 1)
						st = ST_UNDER;
					else
						stk[sp-1] = (stk[sp-1] == 0) ? 16'sd1 : 16'sd0;
				end
				default: begin
					if (sp < 2) begin
						st = ST_UNDER;
					end else begin
						a = stk[sp-1];
						b = stk[sp-2];
						sp -= 2;
						case (it.command)
							CMD_EQ:  v = DATA_W'(a == b);
							CMD_AND: v = DATA_W'(a != 0 && b != 0);
							CMD_OR:  v = DATA_W'(a != 0 || b != 0);
							CMD_XOR: v = DATA_W'((a != 0) != (b != 0));
							CMD_GRT: v = DATA_W'(a > b);
							CMD_ADD: v = b + a;
							CMD_SUB: v = b - a;
							CMD_MUL: v = b * a;
							default: begin
								if (a == 0) begin
									v = '0;
									st = ST_DIVZ;
								end else if (a == -16'sd1) begin
									v = -b;
								end else begin
									v = b / a;
								end
							end
						endcase
						void'(push_word(v));
					end
				end
			endcase
		end
		r.top_value   = (sp > 0) ? stk[sp-1] : '0;
		r.stack_count = sp[4:0];
		r.status      = st;
		r.running     = started && !ended;
		r.finished    = ended;
		status_seen[st]++;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d: %s", result_count, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input integer got, input integer exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp_val));
	endtask

	// stimulus construction
	task automatic add_item(input logic [4:0] code, input logic [DATA_W-1:0] value);
		pending_t p;
		p.item.command = code;
		p.item.operand = value;
		p.hold = hold_next;
		hold_next = 1'b0;
		pending_q.push_back(p);
	endtask

	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return MAX_POS;
			1: return MAX_NEG;
			2: return '0;
			3: return '1;
			4, 5: return DATA_W'($urandom_range(0, 6) - 3);
			default: return DATA_W'($urandom);
		endcase
	endfunction

	function automatic sme_cmd_t rand_alu_op();
		case ($urandom_range(0, 7))
			0: return CMD_EQ;
			1: return CMD_AND;
			2: return CMD_OR;
			3: return CMD_XOR;
			4: return CMD_GRT;
			5: return CMD_ADD;
			6: return CMD_SUB;
			default: return CMD_MUL;
		endcase
	endfunction

	function automatic logic [4:0] rand_body_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return CMD_PUSH;
		if (r < 46) return CMD_JMPIF;
		if (r < 53) return CMD_JMPZ;
		if (r < 58) return CMD_NOT;
		if (r < 64) return CMD_DIV;
		if (r < 95) return rand_alu_op();
		if (r < 97) return CMD_START;
		if (r < 98) return CMD_PRELOAD;
		return 5'($urandom_range(int'(CMD_END) + 1, CMD_TOP));
	endfunction

	task automatic build_program();
		int kind, n;
		hold_next = (prog_count % 16 == 0);
		prog_count++;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			n = $urandom_range(4, 20);
			repeat (n)
				add_item(5'($urandom_range(0, CMD_TOP)), DATA_W'($urandom));
			return;
		end
		if ($urandom_range(0, 5) != 0)
			add_item(CMD_RESET, DATA_W'($urandom));
		n = (kind == 1) ? $urandom_range(15, 18) : $urandom_range(0, 4);
		repeat (n)
			add_item(CMD_PRELOAD, rand_word());
		if ($urandom_range(0, 9) != 0)
			add_item(CMD_START, DATA_W'($urandom));
		if (kind == 2) begin
			repeat ($urandom_range(14, 20))
				add_item(CMD_PUSH, rand_word());
		end
		repeat ($urandom_range(4, 30))
			add_item(rand_body_cmd(), rand_word());
		if ($urandom_range(0, 7) != 0)
			add_item(CMD_END, DATA_W'($urandom));
		repeat ($urandom_range(0, 2))
			add_item(5'($urandom_range(0, CMD_TOP)), DATA_W'($urandom));
	endtask

	// command driver
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (cmd_valid && !cmd_fired) begin
		end else if (send_gap != 0) begin
			cmd_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_q.size() != 0 && !(pending_q[0].hold && expected_q.size() != 0)) begin
			next_req = pending_q.pop_front();
			cmd <= next_req.item;
			cmd_valid <= 1'b1;
			if ($urandom_range(0, 49) == 0)
				send_burst <= !send_burst;
			send_gap <= send_burst ? 0 : $urandom_range(0, GAP_MAX);
		end else begin
			cmd_valid <= 1'b0;
		end
	end

	// result stall
	always @(negedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left <= $urandom_range(0, GAP_MAX);
		end else if (res_fired) begin
			if ($urandom_range(0, 49) == 0)
				recv_burst <= !recv_burst;
			stall_draw = recv_burst ? 0 : $urandom_range(0, GAP_MAX);
			res_stall <= (stall_draw != 0);
			stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
		end else if (stall_left != 0) begin
			res_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_fired <= 1'b0;
			res_fired <= 1'b0;
		end else begin
			cmd_fired <= cmd_valid && !cmd_stall;
			res_fired <= res_valid && !res_stall;
			if (res_valid && !res_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with no transaction pending");
				end else begin
					want = expected_q.pop_front();
					check_field("top_value", res.top_value, want.top_value);
					check_field("stack_count", res.stack_count, want.stack_count);
					check_field("status", res.status, want.status);
					check_field("running", res.running, want.running);
					check_field("finished", res.finished, want.finished);
				end
				result_count++;
			end
			if (cmd_valid && !cmd_stall) begin
				expected_q.push_back(exec_instr(cmd));
				sent_count++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// directed program
		add_item(CMD_ADD, MAX_POS);
		add_item(CMD_PRELOAD, MAX_POS);
		add_item(CMD_PRELOAD, MAX_NEG);
		add_item(CMD_START, '0);
		add_item(CMD_PRELOAD, 16'd5);
		add_item(CMD_PUSH, '1);
		add_item(CMD_DIV, '0);
		add_item(CMD_GRT, '0);
		add_item(CMD_PUSH, '0);
		add_item(CMD_DIV, MAX_POS);
		add_item(CMD_NOT, '0);
		add_item(CMD_PUSH, 16'd1);
		add_item(CMD_EQ, '0);
		add_item(CMD_PUSH, '0);
		add_item(CMD_XOR, '0);
		add_item(CMD_PUSH, '0);
		add_item(CMD_AND, '0);
		add_item(CMD_OR, '0);
		add_item(CMD_PUSH, 16'd5);
		add_item(CMD_OR, '0);
		add_item(CMD_JMPIF, '0);
		add_item(CMD_MUL, '1);
		add_item(CMD_JMPZ, '0);
		add_item(CMD_JMPZ, '0);
		add_item(CMD_START, '0);
		add_item(CMD_JMPIF, '0);
		add_item(CMD_PUSH, MAX_POS);
		add_item(CMD_PUSH, MAX_POS);
		add_item(CMD_MUL, '0);
		add_item(CMD_END, '0);
		add_item(CMD_PUSH, MAX_NEG);
		while (pending_q.size() < RANDOM_ITEMS)
			build_program();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || cmd_valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands in %0d random programs, %0d results checked",
			sent_count, prog_count, result_count);
		$display("status mix: ok %0d, underflow %0d, overflow %0d, div by zero %0d, ignored %0d",
			status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
			status_seen[ST_DIVZ], status_seen[ST_IGNORED]);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
